// File: rtl/core/one_wire_bus_master_top_assert.svh
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Shared property shorthands for the concurrent checks of the bus master.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, quiet in reset
`define OWBM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet in reset
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// One-wire bus master package
// Types, codes and defaults shared by the bus master modules.
// ----------------------------------------------------------------------------
package owbm_pkg;

   // Counter width default and configuration port geometry
   localparam int CountWidthDef = 12;
   localparam int RegCount      = 8;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 10;

   // Queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueueAw    = 1;

   // Command codes on the request word
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_RESET  = 3'd1;
   localparam logic [2:0] CMD_WBYTE  = 3'd2;
   localparam logic [2:0] CMD_RBYTE  = 3'd3;
   localparam logic [2:0] CMD_WBIT   = 3'd4;
   localparam logic [2:0] CMD_RBIT   = 3'd5;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_RESET_SAMPLE  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_RESET_RELEASE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_WRITE_ONE     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_WRITE_ZERO    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [CsrIndexWidth-1:0] REG_SLOT          = 3'd7;

   // Register reset values
   localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
   localparam logic [7:0] RESET_SAMPLE_DEF  = 8'd70;
   localparam logic [9:0] RESET_RELEASE_DEF = 10'd410;
   localparam logic [6:0] WRITE_ONE_DEF     = 7'd6;
   localparam logic [6:0] WRITE_ZERO_DEF    = 7'd60;
   localparam logic [6:0] READ_LOW_DEF      = 7'd6;
   localparam logic [6:0] READ_SAMPLE_DEF   = 7'd9;
   localparam logic [7:0] SLOT_DEF          = 8'd70;

   // Classified operation of one tick word
   typedef enum logic [2:0] {
      OP_TICK,
      OP_RESET,
      OP_WBYTE,
      OP_RBYTE,
      OP_WBIT,
      OP_RBIT
   } op_type;

   // Bus sequencer mode
   typedef enum logic [2:0] {
      M_IDLE,
      M_RLOW,
      M_RWAIT,
      M_RREC,
      M_WBYTE,
      M_RBYTE,
      M_WBIT,
      M_RBIT
   } mode_type;

   // Timing registers
   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [7:0] reset_sample_time;
      logic [9:0] reset_release_time;
      logic [6:0] write_one_low_time;
      logic [6:0] write_zero_low_time;
      logic [6:0] read_low_time;
      logic [6:0] read_sample_time;
      logic [7:0] slot_time;
   } cfg_type;

   // One queued tick word
   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       line_in;
   } entry_type;

   // Queue status seen by the back end
   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

endpackage

// File: rtl/core/owbm_if.sv
// ----------------------------------------------------------------------------
// One-wire bus master channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       line_in;

   modport source (output valid, cmd, data_byte, last_byte, line_in, input ready);
   modport sink   (input valid, cmd, data_byte, last_byte, line_in, output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       op_done;
   logic       presence;
   logic [7:0] read_data;
   logic       rejected;
   logic       transfer_done;

   modport source (output valid, drive_low, busy_res, op_done, presence, read_data,
                   rejected, transfer_done, input ready);
   modport sink   (input valid, drive_low, busy_res, op_done, presence, read_data,
                   rejected, transfer_done, output ready);
endinterface

// File: rtl/core/owbm_front.sv
// ----------------------------------------------------------------------------
// One-wire bus master front end
// Accepts tick words and classifies the command into an operation.
// ----------------------------------------------------------------------------
module owbm_front
   import owbm_pkg::*;
(
   owbm_req_if.sink       req_chan,
   input  queue_stat_type q_stat,
   output logic           push,
   output entry_type      push_entry
);

   op_type op;

   // Map command codes; unknown codes act as a plain tick
   always_comb begin
      case (req_chan.cmd)
         CMD_TICK:  op = OP_TICK;
         CMD_RESET: op = OP_RESET;
         CMD_WBYTE: op = OP_WBYTE;
         CMD_RBYTE: op = OP_RBYTE;
         CMD_WBIT:  op = OP_WBIT;
         CMD_RBIT:  op = OP_RBIT;
         default:   op = OP_TICK;
      endcase
   end

   // Take a word whenever the queue has room
   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

   assign push_entry.op        = op;
   assign push_entry.data_byte = req_chan.data_byte;
   assign push_entry.last_byte = req_chan.last_byte;
   assign push_entry.line_in   = req_chan.line_in;

endmodule

// File: rtl/core/owbm_queue.sv
// ----------------------------------------------------------------------------
// One-wire bus master queue
// Short FIFO of classified tick words between front and back end.
// ----------------------------------------------------------------------------
module owbm_queue
   import owbm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_entry,
   input  logic           pop,
   output entry_type      head,
   output queue_stat_type q_stat
);

   entry_type          mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]   count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueueAw'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QueueAw'(1) : rd_ptr_ff;
      count_in  = count_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == (QueueAw+1)'(QueueDepth));

endmodule

// File: rtl/core/owbm_exec.sv
// ----------------------------------------------------------------------------
// One-wire bus master back end; registers status.
// Runs reset and bit-slot timing one tick word per cycle unless stalled.
// ----------------------------------------------------------------------------
module owbm_exec
   import owbm_pkg::*;
#(
   parameter int CountWidth = CountWidthDef
)
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_stat_type q_stat,
   input  entry_type      head,
   output logic           pop,
   owbm_rsp_if.source     rsp_chan
);

   localparam int CmpW = (CountWidth > 10) ? CountWidth : 10;

   // Sequencer state
   mode_type              mode_ff, mode_in;
   logic [CountWidth-1:0] tc_ff, tc_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  pres_ff, pres_in;
   logic                  last_ff, last_in;
   logic [7:0]            rdata_ff, rdata_in;

   // Output register
   logic                  rsp_valid_ff;
   logic                  drive_ff, busy_ff, done_ff, rej_ff, xfer_ff;
   logic                  drive, done, xfer;

   // Effective state after command start
   logic                  is_cmd, start, rej;
   mode_type              em;
   logic [CountWidth-1:0] et, tc_inc;
   logic [2:0]            eb;
   logic [7:0]            es;
   logic                  elast;

   // Timing terms
   logic [9:0]            rlow;
   logic [7:0]            len, lenm1, low_nz, lowt, sp;
   logic [6:0]            raw_low;
   logic [8:0]            sp_sum;
   logic                  is_read, is_byte, bitv, more_bits;
   logic                  rlow_end, rwait_end, rrec_end, slot_end;

   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp_chan.ready);

   // Start a command when idle, flag it when busy
   always_comb begin
      is_cmd = (head.op != OP_TICK);
      start  = is_cmd && (mode_ff == M_IDLE);
      rej    = is_cmd && (mode_ff != M_IDLE);
      em     = mode_ff;
      et     = tc_ff;
      eb     = bit_ff;
      es     = shift_ff;
      elast  = last_ff;
      if (start) begin
         et    = '0;
         eb    = '0;
         es    = '0;
         elast = 1'b0;
         case (head.op)
            OP_RESET: em = M_RLOW;
            OP_WBYTE: begin
               em    = M_WBYTE;
               es    = head.data_byte;
               elast = head.last_byte;
            end
            OP_RBYTE: begin
               em    = M_RBYTE;
               elast = head.last_byte;
            end
            OP_WBIT: begin
               em = M_WBIT;
               es = {7'd0, head.data_byte[0]};
            end
            OP_RBIT: em = M_RBIT;
            default: em = mode_ff;
         endcase
      end
   end

   // Slot timing and end conditions
   always_comb begin
      tc_inc    = et + CountWidth'(1);
      rlow      = (cfg.reset_low_time == '0) ? 10'd1 : cfg.reset_low_time;
      rlow_end  = CmpW'(tc_inc) >= CmpW'(rlow);
      rwait_end = CmpW'(et) >= CmpW'(cfg.reset_sample_time);
      rrec_end  = CmpW'(tc_inc) >= CmpW'(cfg.reset_release_time);
      len       = (cfg.slot_time < 8'd2) ? 8'd2 : cfg.slot_time;
      lenm1     = len - 8'd1;
      is_read   = (em == M_RBYTE) || (em == M_RBIT);
      is_byte   = (em == M_WBYTE) || (em == M_RBYTE);
      bitv      = es[eb];
      if (is_read) begin
         raw_low = cfg.read_low_time;
      end else if (bitv) begin
         raw_low = cfg.write_one_low_time;
      end else begin
         raw_low = cfg.write_zero_low_time;
      end
      low_nz    = (raw_low == '0) ? 8'd1 : {1'b0, raw_low};
      lowt      = (low_nz > lenm1) ? lenm1 : low_nz;
      sp_sum    = {1'b0, lowt} + {2'b00, cfg.read_sample_time};
      sp        = (sp_sum > {1'b0, lenm1}) ? lenm1 : sp_sum[7:0];
      slot_end  = CmpW'(et) >= CmpW'(lenm1);
      more_bits = is_byte && (eb != 3'd7);
   end

   // Next mode
   always_comb begin
      mode_in = em;
      case (em)
         M_IDLE:  mode_in = M_IDLE;
         M_RLOW:  mode_in = rlow_end ? M_RWAIT : M_RLOW;
         M_RWAIT: mode_in = rwait_end ? M_RREC : M_RWAIT;
         M_RREC:  mode_in = rrec_end ? M_IDLE : M_RREC;
         M_WBYTE, M_RBYTE, M_WBIT, M_RBIT: begin
            mode_in = (slot_end && !more_bits) ? M_IDLE : em;
         end
         default: mode_in = M_IDLE;
      endcase
   end

   // Counters, shifter and status for this tick
   always_comb begin
      drive    = 1'b0;
      done     = 1'b0;
      xfer     = 1'b0;
      tc_in    = et;
      bit_in   = eb;
      shift_in = es;
      last_in  = elast;
      pres_in  = pres_ff;
      rdata_in = rdata_ff;
      case (em)
         M_IDLE: tc_in = et;
         M_RLOW: begin
            drive = 1'b1;
            tc_in = rlow_end ? '0 : tc_inc;
         end
         M_RWAIT: begin
            if (rwait_end) begin
               pres_in = !head.line_in;
               tc_in   = '0;
            end else begin
               tc_in = tc_inc;
            end
         end
         M_RREC: begin
            done  = rrec_end;
            tc_in = rrec_end ? '0 : tc_inc;
         end
         M_WBYTE, M_RBYTE, M_WBIT, M_RBIT: begin
            if (is_read && (CmpW'(et) == CmpW'(sp)) && head.line_in) begin
               shift_in = es | (8'd1 << eb);
            end
            drive = CmpW'(et) < CmpW'(lowt);
            if (slot_end) begin
               tc_in = '0;
               if (more_bits) begin
                  bit_in = eb + 3'd1;
               end else begin
                  if (is_read) begin
                     rdata_in = shift_in;
                  end
                  done   = 1'b1;
                  xfer   = elast;
                  bit_in = '0;
               end
            end else begin
               tc_in = tc_inc;
            end
         end
         default: tc_in = et;
      endcase
   end

   // Hold state; advance on each popped word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         tc_ff    <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         last_ff  <= 1'b0;
         rdata_ff <= '0;
      end else if (pop) begin
         mode_ff  <= mode_in;
         tc_ff    <= tc_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         last_ff  <= last_in;
         rdata_ff <= rdata_in;
      end
   end

   // Output word valid: set on pop, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output word payload
   always_ff @(posedge clock) begin
      if (pop) begin
         drive_ff <= drive;
         busy_ff  <= (mode_in != M_IDLE);
         done_ff  <= done;
         rej_ff   <= rej;
         xfer_ff  <= xfer;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drive_low     = drive_ff;
   assign rsp_chan.busy_res      = busy_ff;
   assign rsp_chan.op_done       = done_ff;
   assign rsp_chan.presence      = pres_ff;
   assign rsp_chan.read_data     = rdata_ff;
   assign rsp_chan.rejected      = rej_ff;
   assign rsp_chan.transfer_done = xfer_ff;

endmodule

// File: rtl/core/one_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// One-wire bus master top level
// Timing registers, front end, word queue and bus sequencer.
// ----------------------------------------------------------------------------
// Feed one request word per microsecond tick; each word yields exactly one
// response word telling whether to pull the bus low during that tick, plus
// status. The block takes one word every clock cycle while the queue has
// room; a word's response passes through the two-entry queue and then the
// sequencer's output register. Either side may stall independently; the queue
// and the output register absorb it. The user must write timing registers
// through the csr_ port only while no word is in flight; the block does not
// enforce this. Timing registers reset to the standard slot timings.
module one_wire_bus_master_top
   import owbm_pkg::*;
#(
   parameter int CountWidth = CountWidthDef
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   owbm_req_if.sink                 req_chan,
   owbm_rsp_if.source               rsp_chan
);

`include "one_wire_bus_master_top_assert.svh"

   cfg_type        cfg_ff, cfg_in;
   queue_stat_type q_stat;
   entry_type      push_entry, head;
   logic           push, pop;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low_time      = csr_wdata[9:0];
            REG_RESET_SAMPLE:  cfg_in.reset_sample_time   = csr_wdata[7:0];
            REG_RESET_RELEASE: cfg_in.reset_release_time  = csr_wdata[9:0];
            REG_WRITE_ONE:     cfg_in.write_one_low_time  = csr_wdata[6:0];
            REG_WRITE_ZERO:    cfg_in.write_zero_low_time = csr_wdata[6:0];
            REG_READ_LOW:      cfg_in.read_low_time       = csr_wdata[6:0];
            REG_READ_SAMPLE:   cfg_in.read_sample_time    = csr_wdata[6:0];
            REG_SLOT:          cfg_in.slot_time           = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time      <= RESET_LOW_DEF;
         cfg_ff.reset_sample_time   <= RESET_SAMPLE_DEF;
         cfg_ff.reset_release_time  <= RESET_RELEASE_DEF;
         cfg_ff.write_one_low_time  <= WRITE_ONE_DEF;
         cfg_ff.write_zero_low_time <= WRITE_ZERO_DEF;
         cfg_ff.read_low_time       <= READ_LOW_DEF;
         cfg_ff.read_sample_time    <= READ_SAMPLE_DEF;
         cfg_ff.slot_time           <= SLOT_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   owbm_front u_front (
      .req_chan   (req_chan),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   owbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   owbm_exec #(
      .CountWidth (CountWidth)
   ) u_exec (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // An accepted word is queued on the next cycle
   `OWBM_ASSERT_NEXT(a_accept_queued, req_chan.valid && req_chan.ready, !q_stat.empty, "accepted word not queued")
   // A finished operation leaves the sequencer idle
   `OWBM_ASSERT_NOW(a_done_idle, rsp_chan.valid && rsp_chan.op_done, !rsp_chan.busy_res, "done while busy")
   // A completed transfer is always a completed operation
   `OWBM_ASSERT_NOW(a_xfer_done, rsp_chan.valid && rsp_chan.transfer_done, rsp_chan.op_done, "transfer_done without op_done")

endmodule

// File: sim/one_wire_bus_master_top_tb.sv
// ----------------------------------------------------------------------------
// One-wire bus master testbench
// Streams microsecond tick words into the bus master and predicts every
// response word with a cycle-accurate model of the reset, write and read
// slot sequencer. Responses are checked field by field in order. The run
// covers default, tiny, degenerate and maximum slot timings, then random
// timings with random command traffic, under random stalls on both channels.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top_tb;
   import owbm_pkg::*;

   localparam int CYCLE_LIMIT = 40000;
   localparam int TICK_MASK   = (1 << CountWidthDef) - 1;
   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_ANY    = 2;
   localparam int HOLD_CYCLES = 60;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       line_in;
   } bus_tick_t;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       op_done;
      logic       presence;
      logic [7:0] read_data;
      logic       rejected;
      logic       transfer_done;
   } bus_status_t;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   owbm_req_if req_bus ();
   owbm_rsp_if rsp_bus ();

   one_wire_bus_master_top DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Pending tick words and expected status words
   bus_tick_t   tick_words[$];
   bus_status_t status_due[$];

   // Predicted sequencer state and timing registers
   cfg_type                  timing;
   mode_type                 seq_mode;
   logic [CountWidthDef-1:0] seq_ticks;
   logic [2:0]               seq_bit;
   logic [7:0]               seq_shift;
   logic                     seq_presence;
   logic                     seq_last;
   logic [7:0]               seq_read;

   bit no_gaps;
   int mismatches;
   int cycle_count;
   int words_sent;
   int status_seen;
   int ops_done;
   int cmds_rejected;
   int transfers_done;
   int timing_sets;
   int hold_left;
   int next_hold_at;

   // Clamp a slot low time so the slot keeps one released tick
   function automatic int unsigned slot_low(int unsigned lowt, int unsigned len);
      if (lowt < 1) lowt = 1;
      if (lowt > len - 1) lowt = len - 1;
      return lowt;
   endfunction

   // Advance the predicted sequencer by one tick word
   task automatic advance_bus(input bus_tick_t w, output bus_status_t s);
      int unsigned tc;
      int unsigned lowt;
      int unsigned len;
      int unsigned sample_at;
      int unsigned b;
      logic [2:0]  cmd;
      logic        drive;
      logic        done;
      logic        rej;
      logic        xfer;
      logic        is_read;
      logic        is_byte;

      tc    = seq_ticks;
      drive = 1'b0;
      done  = 1'b0;
      rej   = 1'b0;
      xfer  = 1'b0;
      cmd   = (w.cmd > CMD_RBIT) ? CMD_TICK : w.cmd;

      // Start a command, or reject it while busy
      if (cmd != CMD_TICK) begin
         if (seq_mode != M_IDLE) begin
            rej = 1'b1;
         end else begin
            tc       = 0;
            seq_bit  = '0;
            seq_last = 1'b0;
            case (cmd)
               CMD_RESET: seq_mode = M_RLOW;
               CMD_WBYTE: begin
                  seq_mode  = M_WBYTE;
                  seq_shift = w.data_byte;
                  seq_last  = w.last_byte;
               end
               CMD_RBYTE: begin
                  seq_mode  = M_RBYTE;
                  seq_shift = '0;
                  seq_last  = w.last_byte;
               end
               CMD_WBIT: begin
                  seq_mode  = M_WBIT;
                  seq_shift = {7'd0, w.data_byte[0]};
               end
               default: begin
                  seq_mode  = M_RBIT;
                  seq_shift = '0;
               end
            endcase
         end
      end

      case (seq_mode)
         M_IDLE: ;
         // Hold the line low for the reset pulse
         M_RLOW: begin
            lowt  = (timing.reset_low_time == 0) ? 1 : timing.reset_low_time;
            drive = 1'b1;
            tc    = (tc + 1) & TICK_MASK;
            if (tc >= lowt) begin
               seq_mode = M_RWAIT;
               tc       = 0;
            end
         end
         // Wait for the presence sample point
         M_RWAIT: begin
            if (tc >= timing.reset_sample_time) begin
               seq_presence = !w.line_in;
               seq_mode     = M_RREC;
               tc           = 0;
            end else begin
               tc = (tc + 1) & TICK_MASK;
            end
         end
         // Wait out the recovery time
         M_RREC: begin
            tc = (tc + 1) & TICK_MASK;
            if (tc >= timing.reset_release_time) begin
               seq_mode = M_IDLE;
               tc       = 0;
               done     = 1'b1;
            end
         end
         // Write or read bit slot
         default: begin
            len     = (timing.slot_time < 2) ? 2 : timing.slot_time;
            is_read = (seq_mode == M_RBYTE) || (seq_mode == M_RBIT);
            is_byte = (seq_mode == M_WBYTE) || (seq_mode == M_RBYTE);
            b       = seq_bit;
            if (is_read) begin
               lowt      = slot_low(timing.read_low_time, len);
               sample_at = lowt + timing.read_sample_time;
               if (sample_at > len - 1) sample_at = len - 1;
               if (tc == sample_at && w.line_in) seq_shift[b] = 1'b1;
            end else begin
               lowt = slot_low(seq_shift[b] ? timing.write_one_low_time
                                            : timing.write_zero_low_time, len);
            end
            drive = (tc < lowt);
            if (tc >= len - 1) begin
               if (is_byte && b < 7) begin
                  seq_bit = 3'(b + 1);
                  tc      = 0;
               end else begin
                  if (is_read) seq_read = seq_shift;
                  done     = 1'b1;
                  xfer     = seq_last;
                  seq_mode = M_IDLE;
                  tc       = 0;
                  seq_bit  = '0;
               end
            end else begin
               tc = (tc + 1) & TICK_MASK;
            end
         end
      endcase
      seq_ticks = CountWidthDef'(tc);

      s = '{drive, seq_mode != M_IDLE, done, seq_presence, seq_read, rej, xfer};
   endtask

   // Compare one status field
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         if (mismatches < 20)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   function automatic logic pick_line(int mode);
      if (mode == LINE_ANY) return logic'($urandom_range(1));
      return (mode == LINE_HIGH);
   endfunction

   task automatic send_word(input logic [2:0] cmd, input logic [7:0] data,
                            input logic last, input logic line);
      tick_words.push_back('{cmd, data, last, line});
   endtask

   // Queue a command followed by tick-only words
   task automatic send_op(input logic [2:0] cmd, input logic [7:0] data, input logic last,
                          input int line_mode, input int ticks);
      send_word(cmd, data, last, pick_line(line_mode));
      repeat (ticks) send_word(CMD_TICK, 8'($urandom), 1'($urandom), pick_line(line_mode));
   endtask

   // Wait until every word is answered and the sequencer is idle
   task automatic drain_bus();
      do begin
         if (seq_mode != M_IDLE) repeat (64) send_op(CMD_TICK, 8'h00, 1'b0, LINE_ANY, 0);
         while (tick_words.size() != 0 || req_bus.valid || status_due.size() != 0)
            @(posedge clock);
      end while (seq_mode != M_IDLE);
      repeat (4) @(posedge clock);
   endtask

   // Write all timing registers on back-to-back cycles
   task automatic load_timing(input cfg_type c);
      logic [CsrIndexWidth-1:0] idx;
      for (int i = 0; i < RegCount; i++) begin
         idx = i[CsrIndexWidth-1:0];
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         case (idx)
            REG_RESET_LOW:     csr_wdata <= c.reset_low_time;
            REG_RESET_SAMPLE:  csr_wdata <= CsrDataWidth'(c.reset_sample_time);
            REG_RESET_RELEASE: csr_wdata <= c.reset_release_time;
            REG_WRITE_ONE:     csr_wdata <= CsrDataWidth'(c.write_one_low_time);
            REG_WRITE_ZERO:    csr_wdata <= CsrDataWidth'(c.write_zero_low_time);
            REG_READ_LOW:      csr_wdata <= CsrDataWidth'(c.read_low_time);
            REG_READ_SAMPLE:   csr_wdata <= CsrDataWidth'(c.read_sample_time);
            default:           csr_wdata <= CsrDataWidth'(c.slot_time);
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
      timing = c;
      timing_sets++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Request driver: offer queued words, predict each accepted one
   always @(posedge clock) begin : drive_words
      bus_tick_t   nxt;
      bus_status_t want;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_bus('{req_bus.cmd, req_bus.data_byte, req_bus.last_byte,
                          req_bus.line_in}, want);
            status_due.push_back(want);
            words_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (tick_words.size() != 0 && (no_gaps || $urandom_range(99) >= 33)) begin
               nxt = tick_words.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.cmd       <= nxt.cmd;
               req_bus.data_byte <= nxt.data_byte;
               req_bus.last_byte <= nxt.last_byte;
               req_bus.line_in   <= nxt.line_in;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off: now and then count out a long stretch of stalled cycles
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left    <= 0;
         next_hold_at <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (status_seen >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 800;
      end
   end

   // Response monitor: check each accepted word, stall at random
   always @(posedge clock) begin : watch_status
      bus_status_t want;
      bus_status_t got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.drive_low, rsp_bus.busy_res, rsp_bus.op_done, rsp_bus.presence,
                    rsp_bus.read_data, rsp_bus.rejected, rsp_bus.transfer_done};
            status_seen++;
            ops_done       += got.op_done;
            cmds_rejected  += got.rejected;
            transfers_done += got.transfer_done;
            if (status_due.size() == 0) begin
               if (mismatches < 20)
                  $display("%0t: status word with none expected, actual %0h", $time, got);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("drive_low", want.drive_low, got.drive_low);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("op_done", want.op_done, got.op_done);
               check_field("presence", want.presence, got.presence);
               check_field("read_data", want.read_data, got.read_data);
               check_field("rejected", want.rejected, got.rejected);
               check_field("transfer_done", want.transfer_done, got.transfer_done);
            end
         end
         // Hold off during a long stretch so the input backs up
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 33);
         end
      end
   end

   // Stimulus and end of run
   initial begin : run_phases
      cfg_type c;
      int      r;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_TICK;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      req_bus.line_in   = 1'b1;
      rsp_bus.ready     = 1'b0;
      no_gaps           = 1'b0;
      mismatches        = 0;
      cycle_count       = 0;
      timing = '{RESET_LOW_DEF, RESET_SAMPLE_DEF, RESET_RELEASE_DEF, WRITE_ONE_DEF,
                 WRITE_ZERO_DEF, READ_LOW_DEF, READ_SAMPLE_DEF, SLOT_DEF};
      seq_mode     = M_IDLE;
      seq_ticks    = '0;
      seq_bit      = '0;
      seq_shift    = '0;
      seq_presence = 1'b0;
      seq_last     = 1'b0;
      seq_read     = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Default timings straight out of reset
      send_op(CMD_WBIT, 8'h01, 1'b1, LINE_ANY, 80);
      send_op(CMD_RBIT, 8'h00, 1'b1, LINE_HIGH, 80);
      drain_bus();

      // Tiny slots: every command, data extremes, busy and unknown commands
      c = '{10'd3, 8'd2, 10'd3, 7'd1, 7'd3, 7'd1, 7'd1, 8'd5};
      load_timing(c);
      send_op(CMD_RESET, 8'h00, 1'b0, LINE_LOW, 14);
      send_op(CMD_RESET, 8'hFF, 1'b1, LINE_HIGH, 2);
      send_op(CMD_WBYTE, 8'h5A, 1'b1, LINE_HIGH, 0);
      send_op(3'd6, 8'h00, 1'b0, LINE_HIGH, 14);
      send_op(CMD_WBYTE, 8'hFF, 1'b1, LINE_ANY, 44);
      send_op(CMD_WBYTE, 8'h00, 1'b0, LINE_ANY, 44);
      send_op(CMD_WBYTE, 8'hA5, 1'b1, LINE_ANY, 3);
      send_op(CMD_RBIT, 8'h00, 1'b0, LINE_ANY, 1);
      send_op(3'd7, 8'hFF, 1'b1, LINE_ANY, 44);
      send_op(CMD_RBYTE, 8'h00, 1'b1, LINE_HIGH, 44);
      send_op(CMD_RBYTE, 8'hFF, 1'b0, LINE_LOW, 44);
      send_op(CMD_RBYTE, 8'h3C, 1'b1, LINE_ANY, 44);
      send_op(CMD_WBIT, 8'hFE, 1'b1, LINE_ANY, 8);
      send_op(CMD_WBIT, 8'h01, 1'b1, LINE_ANY, 8);
      send_op(CMD_RBIT, 8'hFF, 1'b1, LINE_HIGH, 8);
      send_op(CMD_RBIT, 8'h00, 1'b0, LINE_LOW, 8);
      send_op(3'd7, 8'h81, 1'b0, LINE_ANY, 4);
      drain_bus();

      // Degenerate timings: zero times, short slot, overlong low, late sample
      c = '{10'd0, 8'd0, 10'd0, 7'd127, 7'd0, 7'd0, 7'd127, 8'd1};
      load_timing(c);
      send_op(CMD_RESET, 8'h00, 1'b0, LINE_LOW, 6);
      send_op(CMD_WBYTE, 8'h3C, 1'b1, LINE_ANY, 20);
      send_op(CMD_RBYTE, 8'h00, 1'b1, LINE_ANY, 20);
      send_op(CMD_WBIT, 8'h01, 1'b0, LINE_ANY, 4);
      send_op(CMD_RBIT, 8'h00, 1'b0, LINE_HIGH, 4);
      drain_bus();

      // Largest timings: longest bit slots
      c = '{10'd1023, 8'd255, 10'd1023, 7'd127, 7'd127, 7'd127, 7'd127, 8'd255};
      load_timing(c);
      send_op(CMD_WBIT, 8'h00, 1'b1, LINE_ANY, 260);
      send_op(CMD_RBIT, 8'h00, 1'b0, LINE_HIGH, 260);
      drain_bus();

      // Random timings with random command traffic
      for (int phase = 0; phase < 5; phase++) begin
         c.reset_low_time      = 10'($urandom_range(0, 12));
         c.reset_sample_time   = 8'($urandom_range(0, 10));
         c.reset_release_time  = 10'($urandom_range(0, 12));
         c.write_one_low_time  = 7'($urandom_range(0, 14));
         c.write_zero_low_time = 7'($urandom_range(0, 14));
         c.read_low_time       = 7'($urandom_range(0, 10));
         c.read_sample_time    = 7'($urandom_range(0, 10));
         c.slot_time           = 8'($urandom_range(1, 14));
         load_timing(c);
         no_gaps = (phase == 2);
         repeat ((phase == 2) ? 120 : 40) begin
            r = $urandom_range(99);
            if (r < 12)
               send_word(3'($urandom_range(1, 5)), 8'($urandom), 1'($urandom),
                         1'($urandom));
            else if (r < 15)
               send_word(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom),
                         1'($urandom));
            else
               send_word(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
         end
         drain_bus();
         no_gaps = 1'b0;
      end

      if (status_due.size() != 0) begin
         $display("%0t: %0d status words never arrived", $time, status_due.size());
         mismatches++;
      end
      $display("Ran %0d tick words over %0d timing settings plus defaults.",
               words_sent, timing_sets);
      $display("Saw %0d finished operations, %0d rejected commands, %0d last-byte ends.",
               ops_done, cmds_rejected, transfers_done);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
